// ----- design/nsfbm_pkg.sv -----
// ----------------------------------------------------------------------------
// nsfbm_pkg
// Types, codes and address constants shared by the NSF bank mapper modules.
// ----------------------------------------------------------------------------
package nsfbm_pkg;

  localparam int NUM_BANKS        = 8;
  localparam int BANK_IDX_W       = $clog2(NUM_BANKS);
  localparam int DRIVER_ROM_BYTES = 64;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // result sources
  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_DIRECT = 2'd1;
  localparam logic [1:0] SRC_DRIVER = 2'd2;
  localparam logic [1:0] SRC_IMAGE  = 2'd3;

  // config register indexes
  localparam logic [2:0] REG_BANK_SWITCHED = 3'd0;
  localparam logic [2:0] REG_ROM_PAGES     = 3'd1;
  localparam logic [2:0] REG_ROM_LENGTH    = 3'd2;
  localparam logic [2:0] REG_LOAD_ADDRESS  = 3'd3;
  localparam logic [2:0] REG_INITIAL_BANKS = 3'd4;
  localparam logic [2:0] REG_INIT_ADDRESS  = 3'd5;
  localparam logic [2:0] REG_PLAY_ADDRESS  = 3'd6;

  // CPU addresses
  localparam logic [15:0] DRV_BASE     = 16'h3800;
  localparam logic [15:0] DRV_RESET    = 16'h3820;
  localparam logic [15:0] ADDR_STATUS  = 16'h3FF0;
  localparam logic [15:0] ADDR_ZERO1   = 16'h3FF1;
  localparam logic [15:0] ADDR_ZERO2   = 16'h3FF2;
  localparam logic [15:0] ADDR_PATCH_OFF = 16'h3FF3;
  localparam logic [15:0] ADDR_PATCH_ON  = 16'h3FF4;
  localparam logic [15:0] ADDR_BANK_LO = 16'h5FF8;
  localparam logic [15:0] ADDR_BANK_HI = 16'h5FFF;
  localparam logic [15:0] ADDR_NMI_LO  = 16'hFFFA;
  localparam logic [15:0] ADDR_NMI_HI  = 16'hFFFB;
  localparam logic [15:0] ADDR_RST_LO  = 16'hFFFC;
  localparam logic [15:0] ADDR_RST_HI  = 16'hFFFD;
  localparam logic [11:0] PAGE_MASK    = 12'hFFF;

  // patched driver ROM byte offsets
  localparam logic [15:0] OFF_INIT_LO = 16'h0012;
  localparam logic [15:0] OFF_INIT_HI = 16'h0013;
  localparam logic [15:0] OFF_PLAY_LO = 16'h0019;
  localparam logic [15:0] OFF_PLAY_HI = 16'h001A;

  localparam logic [15:0] LOAD_ADDRESS_RST = 16'h8000;

  typedef logic [NUM_BANKS-1:0][7:0] bank_arr_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic        claimed;
    logic [1:0]  source;
    logic [7:0]  read_data;
    logic [23:0] mem_offset;
  } result_t;

  typedef struct packed {
    logic        bank_switched;
    logic [12:0] rom_pages;
    logic [23:0] rom_length;
    logic [15:0] load_address;
    logic [15:0] init_address;
    logic [15:0] play_address;
  } cfg_t;

  // bulk bank load from the config port
  typedef struct packed {
    logic      we;
    bank_arr_t banks;
  } bank_load_t;

  // state changes requested by one decoded item
  typedef struct packed {
    logic                  bank_we;
    logic [BANK_IDX_W-1:0] bank_idx;
    logic [7:0]            bank_val;
    logic                  set_pending;
    logic                  clr_pending;
    logic                  set_patch;
    logic                  clr_patch;
  } upd_t;

endpackage

// ----- design/nsfbm_apb.sv -----
// ----------------------------------------------------------------------------
// nsfbm_apb
// APB configuration registers; readback of the live bank registers.
// ----------------------------------------------------------------------------
module nsfbm_apb (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  nsfbm_pkg::bank_arr_t  banks,
  output nsfbm_pkg::cfg_t       cfg,
  output nsfbm_pkg::bank_load_t bank_load
);
  import nsfbm_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bank_switched <= 1'b0;
      cfg.rom_pages     <= '0;
      cfg.rom_length    <= '0;
      cfg.load_address  <= LOAD_ADDRESS_RST;
      cfg.init_address  <= '0;
      cfg.play_address  <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_BANK_SWITCHED: cfg.bank_switched <= pwdata[0];
        REG_ROM_PAGES:     cfg.rom_pages     <= pwdata[12:0];
        REG_ROM_LENGTH:    cfg.rom_length    <= pwdata[23:0];
        REG_LOAD_ADDRESS:  cfg.load_address  <= pwdata[15:0];
        REG_INIT_ADDRESS:  cfg.init_address  <= pwdata[15:0];
        REG_PLAY_ADDRESS:  cfg.play_address  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign bank_load.we    = wr && (idx == REG_INITIAL_BANKS);
  assign bank_load.banks = pwdata;

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BANK_SWITCHED: prdata = {63'b0, cfg.bank_switched};
      REG_ROM_PAGES:     prdata = {51'b0, cfg.rom_pages};
      REG_ROM_LENGTH:    prdata = {40'b0, cfg.rom_length};
      REG_LOAD_ADDRESS:  prdata = {48'b0, cfg.load_address};
      REG_INITIAL_BANKS: prdata = banks;
      REG_INIT_ADDRESS:  prdata = {48'b0, cfg.init_address};
      REG_PLAY_ADDRESS:  prdata = {48'b0, cfg.play_address};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- design/nsfbm_state.sv -----
// ----------------------------------------------------------------------------
// nsfbm_state
// Bank registers and player flags, with bank clamping against rom_pages.
// ----------------------------------------------------------------------------
module nsfbm_state (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [12:0]           rom_pages,
  input  nsfbm_pkg::bank_load_t bank_load,
  input  nsfbm_pkg::upd_t       upd,
  output nsfbm_pkg::bank_arr_t  banks,
  output logic                  init_pending,
  output logic                  vec_patch
);
  import nsfbm_pkg::*;

  // out-of-range bank numbers map to page 0
  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [12:0] pages);
    return ({5'b0, v} >= pages) ? 8'd0 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      banks         <= '0;
      init_pending  <= 1'b1;
      vec_patch     <= 1'b1;
    end else begin
      if (bank_load.we) begin
        for (int i = 0; i < NUM_BANKS; i++) begin
          banks[i] <= clamp(bank_load.banks[i], rom_pages);
        end
      end else if (upd.bank_we) begin
        banks[upd.bank_idx] <= clamp(upd.bank_val, rom_pages);
      end
      if (upd.set_pending)      init_pending <= 1'b1;
      else if (upd.clr_pending) init_pending <= 1'b0;
      if (upd.set_patch)        vec_patch <= 1'b1;
      else if (upd.clr_patch)   vec_patch <= 1'b0;
    end
  end

endmodule

// ----- design/nsfbm_decode.sv -----
// ----------------------------------------------------------------------------
// nsfbm_decode
// Address decode of one bus access into a result and state changes.
// ----------------------------------------------------------------------------
module nsfbm_decode #(
  parameter int DRIVER_ROM_BYTES = nsfbm_pkg::DRIVER_ROM_BYTES
) (
  input  nsfbm_pkg::item_t     item,
  input  nsfbm_pkg::cfg_t      cfg,
  input  nsfbm_pkg::bank_arr_t banks,
  input  logic                 init_pending,
  input  logic                 vec_patch,
  output nsfbm_pkg::result_t   res,
  output nsfbm_pkg::upd_t      upd
);
  import nsfbm_pkg::*;

  localparam logic [15:0] WIN_BYTES = 16'(DRIVER_ROM_BYTES);

  logic [15:0] a;
  logic [15:0] win_off;
  logic        in_win;
  logic [15:0] lin_off;
  logic        in_image;
  logic        is_vector;

  assign a         = item.address;
  assign win_off   = a - DRV_BASE;
  assign in_win    = (a >= DRV_BASE) && (win_off < WIN_BYTES);
  assign lin_off   = a - cfg.load_address;
  assign in_image  = (a >= cfg.load_address) && ({8'b0, lin_off} < cfg.rom_length);
  assign is_vector = (a >= ADDR_NMI_LO) && (a <= ADDR_RST_HI);

  always_comb begin
    res = '0;
    upd = '0;
    unique case (item.cmd)
      CMD_READ: begin
        priority if (in_win) begin
          res.claimed = 1'b1;
          res.source  = SRC_DIRECT;
          unique case (win_off)
            OFF_INIT_LO: res.read_data = cfg.init_address[7:0];
            OFF_INIT_HI: res.read_data = cfg.init_address[15:8];
            OFF_PLAY_LO: res.read_data = cfg.play_address[7:0];
            OFF_PLAY_HI: res.read_data = cfg.play_address[15:8];
            default: begin
              res.source     = SRC_DRIVER;
              res.mem_offset = {8'b0, win_off};
            end
          endcase
        end else if (a == ADDR_STATUS) begin
          res.claimed     = 1'b1;
          res.source      = SRC_DIRECT;
          res.read_data   = {7'b0, init_pending};
          upd.clr_pending = 1'b1;
        end else if (a == ADDR_ZERO1 || a == ADDR_ZERO2) begin
          res.claimed = 1'b1;
          res.source  = SRC_DIRECT;
        end else if (a == ADDR_PATCH_OFF) begin
          res.claimed   = 1'b1;
          res.source    = SRC_DIRECT;
          upd.clr_patch = 1'b1;
        end else if (a == ADDR_PATCH_ON) begin
          res.claimed   = 1'b1;
          res.source    = SRC_DIRECT;
          upd.set_patch = 1'b1;
        end else if (!a[15]) begin
          res = '0;
        end else if (vec_patch && is_vector) begin
          res.claimed = 1'b1;
          res.source  = SRC_DIRECT;
          unique case (a)
            ADDR_NMI_LO: res.read_data = DRV_BASE[7:0];
            ADDR_NMI_HI: res.read_data = DRV_BASE[15:8];
            ADDR_RST_LO: res.read_data = DRV_RESET[7:0];
            default:     res.read_data = DRV_RESET[15:8];
          endcase
        end else if (cfg.bank_switched) begin
          res.claimed    = 1'b1;
          res.source     = SRC_IMAGE;
          res.mem_offset = {4'b0, banks[a[12+BANK_IDX_W-1:12]], a[11:0] & PAGE_MASK};
        end else if (in_image) begin
          res.claimed    = 1'b1;
          res.source     = SRC_IMAGE;
          res.mem_offset = {8'b0, lin_off};
        end else begin
          res.claimed = 1'b1;
          res.source  = SRC_DIRECT;
        end
      end
      CMD_WRITE: begin
        if (a >= ADDR_BANK_LO && a <= ADDR_BANK_HI) begin
          res.claimed  = 1'b1;
          res.source   = SRC_NONE;
          upd.bank_we  = 1'b1;
          upd.bank_idx = a[BANK_IDX_W-1:0];
          upd.bank_val = item.write_data;
        end
      end
      CMD_START: upd.set_pending = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- design/nsf_player_bank_mapper_core.sv -----
// ----------------------------------------------------------------------------
// nsf_player_bank_mapper_core
// NSF player bus mapper: driver ROM window, player registers, vector patch
// and 4K bank / linear image decode of 6502 bus accesses.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | tuser: cmd; tdata: address, write_data
//  m_*      | out       | tuser: claimed, source; tdata: read_data, mem_offset
//  APB      | in/out    | config regs at 8*index, 64-bit data
//
//  One transfer per cycle sustained while m_tready holds; each item passes
//  through the input register and then the result register, from which
//  its result is offered.
//  Decode is a single pass of compares and a bank register lookup.
//  A stalled result holds the result register; the input register drains
//  into it as soon as it frees, and the input stalls only while both are full.
//  Reset: init pending and vector patching set, banks 0, load address 0x8000.
// ----------------------------------------------------------------------------
module nsf_player_bank_mapper_core #(
  parameter int DRIVER_ROM_BYTES = nsfbm_pkg::DRIVER_ROM_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // access stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [0] claimed, [2:1] source
  output logic [31:0] m_tdata,   // [7:0] read_data, [31:8] mem_offset
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import nsfbm_pkg::*;

  cfg_t       cfg;
  bank_load_t bank_load;
  bank_arr_t  banks;
  logic       init_pending;
  logic       vec_patch;

  // input register
  logic  in_valid;
  item_t in_item;

  // result register
  logic    out_valid;
  result_t out_res;

  result_t res;
  upd_t    upd;
  upd_t    upd_go;
  logic    advance;

  // item moves from input register to result register
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= s_tuser;
      in_item.address    <= s_tdata[15:0];
      in_item.write_data <= s_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  // state changes only commit when the item actually moves on
  assign upd_go = advance ? upd : '0;

  nsfbm_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .banks     (banks),
    .cfg       (cfg),
    .bank_load (bank_load)
  );

  nsfbm_state u_state (
    .clk           (clk),
    .rst           (rst),
    .rom_pages     (cfg.rom_pages),
    .bank_load     (bank_load),
    .upd           (upd_go),
    .banks         (banks),
    .init_pending  (init_pending),
    .vec_patch     (vec_patch)
  );

  nsfbm_decode #(
    .DRIVER_ROM_BYTES (DRIVER_ROM_BYTES)
  ) u_decode (
    .item          (in_item),
    .cfg           (cfg),
    .banks         (banks),
    .init_pending  (init_pending),
    .vec_patch     (vec_patch),
    .res           (res),
    .upd           (upd)
  );

  assign m_tvalid = out_valid;
  assign m_tuser  = {out_res.source, out_res.claimed};
  assign m_tdata  = {out_res.mem_offset, out_res.read_data};

`ifndef SYNTHESIS
  // an unclaimed result carries all-zero fields
  a_unclaimed_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tuser[2:1] == SRC_NONE && m_tdata == '0))
    else $error("unclaimed result with nonzero fields");

  // direct data never carries a memory offset
  a_direct_no_offset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] == SRC_DIRECT) |-> (m_tdata[31:8] == '0))
    else $error("direct data result with offset");

  // a full input register behind a stalled result blocks new transfers
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipeline is full");

  // reading the status register clears init pending
  a_status_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && in_item.cmd == CMD_READ && in_item.address == ADDR_STATUS) |=>
    !init_pending)
    else $error("init pending not cleared by status read");
`endif

endmodule
